// File: hw/rtl/kcs_pkg.sv
// shared types, constants and helpers of the key checksum server selector
`default_nettype none

package kcs_pkg;

    localparam int BYTE_W    = 8;
    localparam int SUM_W     = 16;
    localparam int CFG_W     = 9;
    localparam int DIV_W     = 32;
    localparam int STEP_W    = $clog2(DIV_W);
    localparam int CFG_MAX   = (1 << CFG_W) - 1;
    localparam logic [SUM_W-1:0] SUM_ONES = 16'hffff;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take;      // input transfer this cycle
        logic step;      // one remainder step
        logic load_out;  // move remainder into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;  // final remainder step this cycle
        logic out_free;  // output register can take a result
    } status_t;

    // ones' complement add with end-around carry
    function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] acc,
                                                 input logic [SUM_W-1:0] word);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/key_checksum_server_select.sv
// top level of the key checksum server selector
`default_nettype none

// Key bytes arrive one per transfer and are paired little-endian into 16-bit
// words for a ones' complement checksum; a final odd byte counts as a low byte.
// The block takes one byte per cycle while accumulating. A transfer with tlast
// or tuser set ends the key: the inverted checksum, widened to 32 bits with an
// all-ones upper half, is reduced modulo the server count by a bit-serial
// remainder unit, one dividend bit per step, and the result is then loaded
// into the output register once that register is free, later if it is still
// held by a stalled sink. Input is not taken until the result is loaded. A server
// count of zero returns index 0 with the no-server flag; counts above
// MAX_SERVERS are treated as MAX_SERVERS. Write the count only while idle.
module key_checksum_server_select
    import kcs_pkg::*;
#(
    parameter int MAX_SERVERS = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,   // server_count
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,    // [7:0] key_byte
    input  wire logic             s_tlast,    // last_byte
    input  wire logic             s_tuser,    // [0] empty_key
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,    // [7:0] server_index
    output logic                  m_tuser     // [0] no_server
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    kcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kcs_datapath #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .key_byte  (s_tdata),
        .last_byte (s_tlast),
        .empty_key (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // no-server results always carry index zero
    a_none_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("no-server result with nonzero index");

    // a result is only loaded when the output register has room
    a_load_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over a pending one");

    // after a key-end transfer the input stays closed while the remainder runs
    a_key_end_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tlast || s_tuser)) |=> (!s_tready && cmd.step))
        else $error("input open during remainder steps");

endmodule

`default_nettype wire

// File: hw/rtl/kcs_ctrl.sv
// sequencing of byte intake, remainder steps and result hand-off
`default_nettype none

module kcs_ctrl
    import kcs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    input  wire logic    s_tlast,
    input  wire logic    s_tuser,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.take     = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_ACCUM: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (s_tlast || s_tuser) begin
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                cmd.step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/kcs_datapath.sv
// checksum accumulator, bit-serial remainder unit and output register
`default_nettype none

module kcs_datapath
    import kcs_pkg::*;
#(
    parameter int MAX_SERVERS = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic [BYTE_W-1:0] key_byte,
    input  wire logic              last_byte,
    input  wire logic              empty_key,
    input  wire cmd_t              cmd,
    output status_t                status,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,
    output logic                   m_tuser
);

    localparam int CLAMP = (MAX_SERVERS > CFG_MAX) ? CFG_MAX : MAX_SERVERS;

    logic [CFG_W-1:0]  server_count_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              odd_reg, odd_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic [DIV_W-1:0]  dividend_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_index_reg;
    logic              out_none_reg;

    logic [CFG_W-1:0]  count;
    logic              key_end;
    logic              add_en;
    logic [SUM_W-1:0]  word;
    logic [SUM_W-1:0]  sum_added;
    logic [CFG_W:0]    trial;
    logic [CFG_W:0]    trial_sub;

    always_comb begin
        if (32'(server_count_reg) > MAX_SERVERS) begin
            count = CFG_W'(CLAMP);
        end else begin
            count = server_count_reg;
        end
    end

    assign key_end = last_byte || empty_key;

    // word to fold in this transfer; an odd byte closes as a low byte at key end
    always_comb begin
        add_en = 1'b0;
        word   = '0;
        if (empty_key) begin
            add_en = odd_reg;
            word   = {{BYTE_W{1'b0}}, held_reg};
        end else if (odd_reg) begin
            add_en = 1'b1;
            word   = {key_byte, held_reg};
        end else if (last_byte) begin
            add_en = 1'b1;
            word   = {{BYTE_W{1'b0}}, key_byte};
        end
    end

    assign sum_added = add_en ? oc_add(sum_reg, word) : sum_reg;

    always_comb begin
        sum_next  = sum_reg;
        odd_next  = odd_reg;
        held_next = held_reg;
        if (cmd.take) begin
            if (key_end) begin
                sum_next  = '0;
                odd_next  = 1'b0;
                held_next = '0;
            end else if (odd_reg) begin
                sum_next  = sum_added;
                odd_next  = 1'b0;
                held_next = '0;
            end else begin
                odd_next  = 1'b1;
                held_next = key_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_count_reg <= '0;
            sum_reg          <= '0;
            odd_reg          <= 1'b0;
            held_reg         <= '0;
        end else begin
            if (cfg_we) begin
                server_count_reg <= cfg_data;
            end
            sum_reg  <= sum_next;
            odd_reg  <= odd_next;
            held_reg <= held_next;
        end
    end

    // restoring remainder, one dividend bit per step, msb first
    assign trial     = {rem_reg, dividend_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, count};

    always_ff @(posedge aclk) begin
        if (cmd.take && key_end) begin
            dividend_reg <= {SUM_ONES, ~sum_added};
            rem_reg      <= '0;
            step_reg     <= '0;
        end else if (cmd.step) begin
            dividend_reg <= {dividend_reg[DIV_W-2:0], 1'b0};
            rem_reg      <= (trial >= {1'b0, count}) ? trial_sub[CFG_W-1:0]
                                                     : trial[CFG_W-1:0];
            step_reg     <= step_reg + STEP_W'(1);
        end
    end

    assign status.div_last = cmd.step && (step_reg == STEP_W'(DIV_W - 1));
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_none_reg  <= (count == '0);
            out_index_reg <= (count == '0) ? '0 : rem_reg[BYTE_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_index_reg;
    assign m_tuser  = out_none_reg;

endmodule

`default_nettype wire

// File: verif/kcs_server_check.sv
// checker of the key checksum server selector: predicts server picks and compares results
`timescale 1ns / 100ps

module kcs_server_check
    import kcs_pkg::*;
#(
    parameter int MAX_SERVERS = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,    // server_count
    input  wire logic             s_tvalid,
    input  wire logic             s_tready,
    input  wire logic [7:0]       s_tdata,     // [7:0] key_byte
    input  wire logic             s_tlast,     // last_byte
    input  wire logic             s_tuser,     // [0] empty_key
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [7:0]       m_tdata,     // [7:0] server_index
    input  wire logic             m_tuser,     // [0] no_server
    output int                    mismatches,
    output int                    picks_pending
);

    typedef struct packed {
        logic [7:0] index;
        logic       none;
    } pick_t;

    pick_t            expected_picks[$];
    logic [CFG_W-1:0] servers;
    logic [15:0]      key_sum;
    logic             have_low;
    logic [7:0]       low_byte;

    initial begin
        mismatches    = 0;
        picks_pending = 0;
    end

    // ones' complement word add, carry out wraps into bit 0
    function automatic logic [15:0] fold_in(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] t;
        t = {1'b0, acc} + {1'b0, word};
        if (t[16]) begin
            t = {1'b0, t[15:0]} + 17'd1;
        end
        return t[15:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last, input logic empty);
        logic [31:0] wide;
        int unsigned n;
        pick_t       p;
        if (!empty) begin
            if (have_low) begin
                key_sum  = fold_in(key_sum, {b, low_byte});
                have_low = 1'b0;
                low_byte = 8'h00;
            end else begin
                low_byte = b;
                have_low = 1'b1;
            end
        end
        if (empty || last) begin
            // a held odd byte counts as a trailing low byte
            if (have_low) begin
                key_sum = fold_in(key_sum, {8'h00, low_byte});
            end
            wide = {16'hffff, ~key_sum};
            n = (servers > MAX_SERVERS) ? MAX_SERVERS : servers;
            if (n == 0) begin
                p.index = 8'h00;
                p.none  = 1'b1;
            end else begin
                p.index = 8'(wide % n);
                p.none  = 1'b0;
            end
            expected_picks.push_back(p);
            key_sum  = 16'h0000;
            have_low = 1'b0;
            low_byte = 8'h00;
        end
    endtask

    task automatic check_pick(input logic [7:0] idx, input logic none);
        pick_t want;
        if (expected_picks.size() == 0) begin
            report_mismatch("unexpected result, index", idx, -1);
        end else begin
            want = expected_picks.pop_front();
            if (idx !== want.index) begin
                report_mismatch("server_index", idx, want.index);
            end
            if (none !== want.none) begin
                report_mismatch("no_server", none, want.none);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_picks.delete();
            servers  = '0;
            key_sum  = 16'h0000;
            have_low = 1'b0;
            low_byte = 8'h00;
        end else begin
            if (cfg_valid && cfg_ready) begin
                servers = cfg_data;
            end
            // older expectations go out before a new one comes in
            if (m_tvalid && m_tready) begin
                check_pick(m_tdata, m_tuser);
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata, s_tlast, s_tuser);
            end
        end
        picks_pending = expected_picks.size();
    end

endmodule

// File: verif/tb.sv
// testbench top of the key checksum server selector: stimulus and verdict
`timescale 1ns / 100ps

module tb;
    import kcs_pkg::*;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'h00;   // [7:0] key_byte
    logic             s_tlast   = 1'b0;    // last_byte
    logic             s_tuser   = 1'b0;    // [0] empty_key
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;             // [7:0] server_index
    logic             m_tuser;             // [0] no_server

    int               mismatches;
    int               picks_pending;
    int               bytes_sent = 0;
    bit               quiet      = 1'b0;
    bit               hold_req   = 1'b0;

    key_checksum_server_select #(.MAX_SERVERS(256)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    kcs_server_check #(.MAX_SERVERS(256)) u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .picks_pending(picks_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'hff;
            1:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input logic empty);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= empty;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // a key of len bytes, closed by last_byte or by a trailing empty_key transfer
    task automatic send_key(input int len, input bit close_empty);
        for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(), (i == len - 1) && !close_empty, 1'b0);
        end
        if (close_empty || len == 0) begin
            send_byte(8'($urandom), 1'($urandom), 1'b1);
        end
    endtask

    task automatic send_random_key();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        send_key(len, $urandom_range(0, 4) == 0);
    endtask

    // let the remainder unit finish before touching the count
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (picks_pending != 0) @(negedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_servers(input logic [CFG_W-1:0] n);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] phase_count[9];
        int               goal;
        bit               hold_sent;

        hold_sent   = 1'b0;
        phase_count = '{9'd1, 9'd511, 9'd257, 9'd3, 9'd255,
                        CFG_W'($urandom_range(2, 254)), 9'd0,
                        CFG_W'($urandom_range(0, 511)), 9'd256};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // count left at reset value zero
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b0, 1'b1);
        wait_drained();

        write_servers(9'd256);
        send_byte(8'ha5, 1'b1, 1'b1);      // empty key, byte and last ignored
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);      // sum of all ones, inverted to zero
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);      // end-around carry
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h80, 1'b1, 1'b0);
        send_byte(8'h12, 1'b0, 1'b0);      // odd key closed by empty flag
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(8'h56, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hfe, 1'b0, 1'b0);      // even key closed by empty flag
        send_byte(8'hdc, 1'b0, 1'b0);
        send_byte(8'hff, 1'b1, 1'b1);
        wait_drained();

        foreach (phase_count[p]) begin
            write_servers(phase_count[p]);
            if (p == 8) begin
                quiet = 1'b1;
            end
            goal = bytes_sent + 100;
            while (bytes_sent < goal) begin
                if (p == 2 && !hold_sent && bytes_sent >= goal - 60) begin
                    hold_req  = 1'b1;
                    hold_sent = 1'b1;
                end
                if (p == 4 && bytes_sent >= goal - 50 && bytes_sent < goal - 40) begin
                    // sender pauses until every pick is back
                    wait_drained();
                    goal = goal - 10;
                end
                send_random_key();
            end
            wait_drained();
        end

        wait_drained();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && picks_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
